// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// All macros sample on clk and are disabled while rst is high.

`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/clmrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package clmrs_pkg;

  localparam int FRAME_COUNT_DEFAULT = 64;
  localparam int ENTRIES_PER_FRAME   = 32;
  localparam int OFF_BITS            = 5;
  localparam int FRAME_IN_W          = 6;
  localparam int FRAME_IN_COUNT      = 64;
  localparam int INDEX_W             = 11;
  localparam int BYTE_W              = 8;
  localparam int CFG_INDEX_W         = 1;
  localparam int CFG_DATA_W          = 2;
  localparam int BLANK_BYTES         = 12;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SCAN  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLANK      = 1'd1;

  localparam logic [1:0] MODE_GREEN_ONLY = 2'd1;
  localparam logic [1:0] MODE_RED_ONLY   = 2'd2;

  localparam logic [1:0] PANEL_LAST   = 2'd3;
  localparam logic [3:0] BLANK_LAST   = 4'(BLANK_BYTES - 1);
  localparam logic [7:0] BYTE_ALL_OFF = 8'hFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_PANEL,
    S_BLANK
  } state_t;

  typedef enum logic [1:0] {
    PH_GREEN,
    PH_RED,
    PH_SEL
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } entry_t;

  // Panel chain order for row r: 2r+17, 2r+16, 2r+1, 2r.
  function automatic logic [OFF_BITS-1:0] panel_off(input logic [1:0] p);
    logic [OFF_BITS-1:0] off;
    case (p)
      2'd0:    off = 5'd17;
      2'd1:    off = 5'd16;
      2'd2:    off = 5'd1;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ----- sv/clmrs_item_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface clmrs_item_if import clmrs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [INDEX_W-1:0]    entry_index;
  logic [BYTE_W-1:0]     green_bits;
  logic [BYTE_W-1:0]     red_bits;
  logic [FRAME_IN_W-1:0] frame_number;

  modport source (output valid, command, entry_index, green_bits, red_bits, frame_number,
                  input ready);
  modport sink (input valid, command, entry_index, green_bits, red_bits, frame_number,
                output ready);
endinterface

`default_nettype wire

// ----- sv/clmrs_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface clmrs_result_if import clmrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] shift_byte;
  logic              latch_after;
  logic              last;

  modport source (output valid, shift_byte, latch_after, last, input ready);
  modport sink (input valid, shift_byte, latch_after, last, output ready);
endinterface

`default_nettype wire

// ----- sv/clmrs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clmrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/cascaded_led_matrix_row_scanner.sv -----
// Write item: stored in the frame RAM at the accepting edge (in-range index only), no result.
// Scan item: S_FETCH reads the first panel from the frame RAM, then S_PANEL registers one byte
// per cycle unless the output stalls (12 bytes, 24 with blanking); busy until the last is loaded.
// Panel reads come from one single-port-read frame RAM, next panel prefetched on the row byte.
// Reset clears the current row, the config registers and the output valid; the frame RAM
// keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cascaded_led_matrix_row_scanner import clmrs_pkg::*; #(
  parameter int FRAME_COUNT = FRAME_COUNT_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  clmrs_item_if.sink                  item,
  clmrs_result_if.source              result
);

  localparam int STORE_DEPTH = FRAME_COUNT * ENTRIES_PER_FRAME;
  localparam int AW          = $clog2(STORE_DEPTH);

  typedef logic [FRAME_IN_COUNT-1:0][7:0] frame_tab_t;

  function automatic frame_tab_t build_frame_tab();
    frame_tab_t t;
    for (int i = 0; i < FRAME_IN_COUNT; i++) begin
      t[i] = 8'(i % FRAME_COUNT);
    end
    return t;
  endfunction

  localparam frame_tab_t FRAME_TAB = build_frame_tab();

  state_t            state, state_next;
  phase_t            phase, phase_next;
  logic [1:0]        panel, panel_next;
  logic [3:0]        blank_cnt, blank_cnt_next;
  logic [2:0]        row, row_next;
  logic [AW-1:0]     base;
  logic [1:0]        color_mode;
  logic              blank_after_row;

  logic              item_acc;
  logic              scan_acc;
  logic              ram_we;
  logic              out_free;
  logic              load;
  logic [1:0]        rd_panel;
  logic [OFF_BITS-1:0] rd_low;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_data;
  entry_t            wr_data;

  logic [BYTE_W-1:0] byte_next;
  logic              latch_next;
  logic              last_next;

  assign item.ready = (state == S_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign scan_acc   = item_acc && (item.command == CMD_SCAN);
  assign ram_we     = item_acc && (item.command == CMD_WRITE)
                      && (32'(item.entry_index) < 32'(STORE_DEPTH));
  assign wr_data    = '{green: item.green_bits, red: item.red_bits};

  assign out_free = !result.valid || result.ready;
  assign load     = out_free && ((state == S_PANEL) || (state == S_BLANK));

  // advance the read address on the row byte so the next panel is ready next cycle
  assign rd_panel = (state == S_PANEL && phase == PH_SEL && load && panel != PANEL_LAST) ?
                    panel + 2'd1 : panel;
  assign rd_low   = OFF_BITS'({row, 1'b0}) + panel_off(rd_panel);
  assign rd_addr  = base | AW'(rd_low);

  clmrs_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(STORE_DEPTH)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(item.entry_index)),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode      <= '0;
      blank_after_row <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR_MODE: color_mode      <= cfg_data[1:0];
        CFG_BLANK:      blank_after_row <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_GREEN;
      panel     <= '0;
      blank_cnt <= '0;
      row       <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      panel     <= panel_next;
      blank_cnt <= blank_cnt_next;
      row       <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_acc) begin
      base <= AW'({FRAME_TAB[item.frame_number], 5'b0});
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    panel_next     = panel;
    blank_cnt_next = blank_cnt;
    row_next       = row;
    byte_next      = BYTE_ALL_OFF;
    latch_next     = 1'b0;
    last_next      = 1'b0;
    case (state)
      S_IDLE: begin
        if (scan_acc) begin
          state_next = S_FETCH;
          phase_next = PH_GREEN;
          panel_next = '0;
        end
      end
      S_FETCH: begin
        state_next = S_PANEL;
      end
      S_PANEL: begin
        case (phase)
          PH_GREEN: byte_next = (color_mode == MODE_RED_ONLY) ? BYTE_ALL_OFF : ~rd_data.green;
          PH_RED:   byte_next = (color_mode == MODE_GREEN_ONLY) ? BYTE_ALL_OFF : ~rd_data.red;
          default:  byte_next = ~(8'h01 << row);
        endcase
        latch_next = (phase == PH_SEL) && (panel == PANEL_LAST);
        last_next  = latch_next && !blank_after_row;
        if (load) begin
          case (phase)
            PH_GREEN: phase_next = PH_RED;
            PH_RED:   phase_next = PH_SEL;
            default: begin
              phase_next = PH_GREEN;
              if (panel == PANEL_LAST) begin
                row_next       = row + 3'd1;
                blank_cnt_next = '0;
                state_next     = blank_after_row ? S_BLANK : S_IDLE;
              end else begin
                panel_next = panel + 2'd1;
              end
            end
          endcase
        end
      end
      S_BLANK: begin
        latch_next = (blank_cnt == BLANK_LAST);
        last_next  = latch_next;
        if (load) begin
          blank_cnt_next = blank_cnt + 4'd1;
          if (blank_cnt == BLANK_LAST) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.shift_byte  <= byte_next;
      result.latch_after <= latch_next;
      result.last        <= last_next;
    end
  end

  `ASSERT_SAME(a_no_write_busy, state != S_IDLE, !ram_we, "frame RAM written during scan")
  `ASSERT_NEXT(a_row_advance, state == S_PANEL && load && phase == PH_SEL && panel == PANEL_LAST, row == $past(row) + 3'd1, "row did not advance after last panel")
  `ASSERT_SAME(a_last_latch, result.valid && result.last, result.latch_after, "last byte without latch")
  `ASSERT_ALWAYS(a_blank_range, state != S_BLANK || blank_cnt <= BLANK_LAST, "blank count overrun")

endmodule

`default_nettype wire

// ----- test/cascaded_led_matrix_row_scanner_tb.sv -----
`timescale 1ns / 1ps

module cascaded_led_matrix_row_scanner_tb;
  import clmrs_pkg::*;

  localparam int STORE_DEPTH   = FRAME_COUNT_DEFAULT * ENTRIES_PER_FRAME;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_RUN       = 20;
  localparam int PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 50;

  localparam logic [1:0] MODE_BOTH   = 2'd0;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] shift_byte;
    logic              latch_after;
    logic              last;
  } chain_byte_t;

  class row_scoreboard;
    logic [BYTE_W-1:0] green_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] red_mem [STORE_DEPTH];
    bit                written [STORE_DEPTH];
    logic [2:0]        row;
    logic [1:0]        color_mode;
    logic              blank_after_row;
    chain_byte_t       chain_q [$];
    int                errors;

    function new();
      row = '0;
      color_mode = MODE_BOTH;
      blank_after_row = 1'b0;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void set_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      if (index == CFG_COLOR_MODE) color_mode = value;
      else if (index == CFG_BLANK) blank_after_row = value[0];
    endfunction

    function int panel_entry(int frame, int p);
      int off [4] = '{17, 16, 1, 0};
      return (frame % FRAME_COUNT_DEFAULT) * ENTRIES_PER_FRAME + 2 * int'(row) + off[2'(p)];
    endfunction

    function void push_byte(logic [BYTE_W-1:0] b, logic latch, logic lst);
      chain_byte_t c;
      c.shift_byte = b;
      c.latch_after = latch;
      c.last = lst;
      chain_q.push_back(c);
    endfunction

    function void note_item(logic cmd, logic [INDEX_W-1:0] idx, logic [BYTE_W-1:0] g,
                            logic [BYTE_W-1:0] r, logic [FRAME_IN_W-1:0] frame);
      logic [BYTE_W-1:0] gb, rb, sel;
      int e;
      if (cmd == CMD_WRITE) begin
        if (idx < STORE_DEPTH) begin
          green_mem[idx] = g;
          red_mem[idx] = r;
          written[idx] = 1'b1;
        end
        return;
      end
      sel = BYTE_ALL_OFF ^ (8'h01 << row);
      for (int p = 0; p < 4; p++) begin
        e = panel_entry(int'(frame), p);
        if (e >= STORE_DEPTH) e = 0;
        gb = ~green_mem[INDEX_W'(e)];
        rb = ~red_mem[INDEX_W'(e)];
        if (color_mode == MODE_RED_ONLY) gb = BYTE_ALL_OFF;
        if (color_mode == MODE_GREEN_ONLY) rb = BYTE_ALL_OFF;
        push_byte(gb, 1'b0, 1'b0);
        push_byte(rb, 1'b0, 1'b0);
        push_byte(sel, p == 3, p == 3 && !blank_after_row);
      end
      if (blank_after_row) begin
        for (int j = 0; j < BLANK_BYTES; j++)
          push_byte(BYTE_ALL_OFF, j == BLANK_BYTES - 1, j == BLANK_BYTES - 1);
      end
      row = row + 3'd1;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [BYTE_W-1:0] b, logic latch, logic lst);
      chain_byte_t c;
      if (chain_q.size() == 0) begin
        report($sformatf("unexpected byte %h", b));
        return;
      end
      c = chain_q.pop_front();
      if (b !== c.shift_byte)
        report($sformatf("shift_byte %h, expected %h", b, c.shift_byte));
      if (latch !== c.latch_after)
        report($sformatf("latch_after %b, expected %b", latch, c.latch_after));
      if (lst !== c.last)
        report($sformatf("last %b, expected %b", lst, c.last));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  clmrs_item_if   item_bus ();
  clmrs_result_if result_bus ();

  cascaded_led_matrix_row_scanner i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_bus),
    .result    (result_bus)
  );

  row_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int idle_cycles;
  int stall_run;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (stall_run < MAX_RUN && $urandom_range(99) < recv_stall_pct) begin
        result_bus.ready <= 1'b0;
        stall_run++;
      end else begin
        result_bus.ready <= 1'b1;
        stall_run = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      sb.check_result(result_bus.shift_byte, result_bus.latch_after, result_bus.last);
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** cascaded_led_matrix_row_scanner: FAILED **");
      $finish;
    end
  end

  task send_item(logic cmd, logic [INDEX_W-1:0] idx, logic [BYTE_W-1:0] g,
                 logic [BYTE_W-1:0] r, logic [FRAME_IN_W-1:0] frame);
    int gap;
    gap = 0;
    @(negedge clk);
    while (gap < MAX_RUN && $urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
      gap++;
    end
    item_bus.valid        <= 1'b1;
    item_bus.command      <= cmd;
    item_bus.entry_index  <= idx;
    item_bus.green_bits   <= g;
    item_bus.red_bits     <= r;
    item_bus.frame_number <= frame;
    do @(posedge clk); while (!item_bus.ready);
    sb.note_item(cmd, idx, g, r, frame);
    items_sent++;
  endtask

  task write_entry(int idx, logic [BYTE_W-1:0] g, logic [BYTE_W-1:0] r);
    send_item(CMD_WRITE, INDEX_W'(idx), g, r, FRAME_IN_W'($urandom));
  endtask

  // fill whatever the current row of this frame still lacks, rewrite some at refresh_pct, then scan
  task scan_frame(int frame, int refresh_pct);
    int e;
    for (int p = 0; p < 4; p++) begin
      e = sb.panel_entry(frame, p);
      if (!sb.written[INDEX_W'(e)] || $urandom_range(99) < refresh_pct)
        write_entry(e, BYTE_W'($urandom), BYTE_W'($urandom));
    end
    send_item(CMD_SCAN, INDEX_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
              FRAME_IN_W'(frame));
  endtask

  task write_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_config(index, value);
  endtask

  task end_items();
    @(negedge clk);
    item_bus.valid <= 1'b0;
  endtask

  task wait_drained();
    while (sb.chain_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task set_idling(idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 76;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 76;
      end
      default: begin
        send_idle_pct = 22;
        recv_stall_pct = 22;
      end
    endcase
  endtask

  task directed_items();
    write_entry(0, 8'h00, 8'hFF);
    write_entry(1, 8'hFF, 8'h00);
    write_entry(16, 8'h80, 8'h01);
    write_entry(17, 8'h55, 8'hAA);
    scan_frame(0, 0);
    write_entry(STORE_DEPTH - 1, 8'hFF, 8'hFF);
    write_entry(2018, 8'h01, 8'h80);
    write_entry(2019, 8'hFE, 8'h7F);
    write_entry(2034, 8'h7F, 8'hFE);
    write_entry(2035, 8'hAA, 8'h55);
    scan_frame(FRAME_IN_COUNT - 1, 0);
  endtask

  task random_items(int target);
    int frame;
    int hot [4];
    foreach (hot[i]) hot[i] = int'($urandom_range(FRAME_IN_COUNT - 1));
    while (items_sent < target) begin
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(1) != 0) frame = hot[2'($urandom_range(3))];
        else frame = int'($urandom_range(FRAME_IN_COUNT - 1));
        scan_frame(frame, 15);
      end else begin
        write_entry(int'($urandom_range(STORE_DEPTH - 1)), BYTE_W'($urandom),
                    BYTE_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [1:0] phase_mode [PHASES] = '{MODE_BOTH, MODE_GREEN_ONLY, MODE_RED_ONLY,
                                        MODE_UNUSED, MODE_BOTH, MODE_RED_ONLY,
                                        MODE_GREEN_ONLY, MODE_UNUSED};
    logic       phase_blank [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_bus.valid = 1'b0;
    item_bus.command = CMD_WRITE;
    item_bus.entry_index = '0;
    item_bus.green_bits = '0;
    item_bus.red_bits = '0;
    item_bus.frame_number = '0;
    result_bus.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    idle_cycles = 0;
    stall_run = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      write_config(CFG_COLOR_MODE, phase_mode[3'(ph)]);
      write_config(CFG_BLANK, {1'b0, phase_blank[3'(ph)]});
      set_idling(idle_mode_t'(ph % 4));
      if (ph == 0) directed_items();
      random_items((ph + 1) * ITEMS_PER_PHASE);
      end_items();
      wait_drained();
    end

    if (sb.chain_q.size() != 0)
      sb.report($sformatf("%0d bytes never arrived", sb.chain_q.size()));
    if (sb.errors == 0)
      $display("** cascaded_led_matrix_row_scanner: PASSED **");
    else
      $display("** cascaded_led_matrix_row_scanner: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/clmrs_pkg.sv
sv/clmrs_item_if.sv
sv/clmrs_result_if.sv
sv/clmrs_ram.sv
sv/cascaded_led_matrix_row_scanner.sv
test/cascaded_led_matrix_row_scanner_tb.sv
